FILE: rtl/core/rau_pkg.sv
// Shared types and constants of the rational arithmetic unit.
package rau_pkg;

	localparam int REQ_W       = 3;
	localparam int RES_NUM_W   = 32;
	localparam int RES_DEN_W   = 31;
	localparam int CMP_W       = 2;
	localparam int OUT_TDATA_W = 72;

	typedef enum logic [REQ_W-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_CMP = 3'd4
	} op_t;

	localparam logic [CMP_W-1:0] CMP_LT = 2'b11;
	localparam logic [CMP_W-1:0] CMP_EQ = 2'b00;
	localparam logic [CMP_W-1:0] CMP_GT = 2'b01;

endpackage

FILE: rtl/core/rau_xprod.sv
// Cross-product unit: one shared multiplier forms the result numerator and denominator.
module rau_xprod import rau_pkg::*; #(
	parameter int OPERAND_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  op_t                       op,
	input  logic [OPERAND_BITS-1:0]   a_num,
	input  logic [OPERAND_BITS-2:0]   a_den,
	input  logic [OPERAND_BITS-1:0]   b_num,
	input  logic [OPERAND_BITS-2:0]   b_den,
	output logic                      done,
	output logic [2*OPERAND_BITS:0]   n,
	output logic [2*OPERAND_BITS:0]   d
);

	localparam int OP_W = OPERAND_BITS + 1;
	localparam int PW   = 2 * OP_W;
	localparam int N_W  = 2 * OPERAND_BITS + 1;

	logic                 busy_q;
	logic [2:0]           step_q;
	logic                 done_q;
	logic [PW-1:0]        p_q [4];
	logic [N_W-1:0]       n_q;
	logic [N_W-1:0]       d_q;

	logic signed [OP_W-1:0] mul_a;
	logic signed [OP_W-1:0] mul_b;
	logic signed [PW-1:0]   prod;
	logic [PW:0]            sum_add;
	logic [PW:0]            sum_sub;

	logic [OP_W-1:0] an_x, ad_x, bn_x, bd_x;

	assign an_x = {a_num[OPERAND_BITS-1], a_num};
	assign bn_x = {b_num[OPERAND_BITS-1], b_num};
	assign ad_x = {2'b00, a_den};
	assign bd_x = {2'b00, b_den};

	always_comb begin
		unique case (step_q[1:0])
			2'd0: begin
				mul_a = an_x;
				mul_b = bd_x;
			end
			2'd1: begin
				mul_a = ad_x;
				mul_b = bn_x;
			end
			2'd2: begin
				mul_a = an_x;
				mul_b = bn_x;
			end
			default: begin
				mul_a = ad_x;
				mul_b = bd_x;
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign sum_add = {p_q[0][PW-1], p_q[0]} + {p_q[1][PW-1], p_q[1]};
	assign sum_sub = {p_q[0][PW-1], p_q[0]} - {p_q[1][PW-1], p_q[1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q[2]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !step_q[2]) begin
			p_q[step_q[1:0]] <= prod;
		end
		if (busy_q && step_q[2]) begin
			unique case (op)
				OP_ADD: begin
					n_q <= sum_add[N_W-1:0];
					d_q <= p_q[3][N_W-1:0];
				end
				OP_SUB, OP_CMP: begin
					n_q <= sum_sub[N_W-1:0];
					d_q <= p_q[3][N_W-1:0];
				end
				OP_MUL: begin
					n_q <= p_q[2][N_W-1:0];
					d_q <= p_q[3][N_W-1:0];
				end
				OP_DIV: begin
					n_q <= p_q[0][N_W-1:0];
					d_q <= p_q[1][N_W-1:0];
				end
				default: begin
					n_q <= '0;
					d_q <= '0;
				end
			endcase
		end
	end

	assign done = done_q;
	assign n    = n_q;
	assign d    = d_q;

endmodule

FILE: rtl/core/rau_reduce.sv
// Reduction unit: binary gcd and two restoring divisions on one shared subtractor.
module rau_reduce #(
	parameter int M_W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [M_W-1:0] x,
	input  logic [M_W-1:0] y,
	output logic           done,
	output logic [M_W-1:0] qx,
	output logic [M_W-1:0] qy
);

	localparam int CNT_W = $clog2(M_W);

	typedef enum logic [1:0] {
		R_IDLE,
		R_GCD,
		R_DIVX,
		R_DIVY
	} rstate_t;

	rstate_t          state_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [M_W-1:0]   u_q, v_q, xs_q, ys_q, rem_q, quo_q, qx_q, qy_q;

	logic             u_gt;
	logic [M_W:0]     sub_a, sub_b;
	logic [M_W+1:0]   diff;
	logic             fits;
	logic [M_W-1:0]   rem_nx;
	logic [M_W-1:0]   quo_nx;

	assign u_gt = u_q > v_q;

	always_comb begin
		if (state_q == R_GCD) begin
			sub_a = u_gt ? {1'b0, u_q} : {1'b0, v_q};
			sub_b = u_gt ? {1'b0, v_q} : {1'b0, u_q};
		end else begin
			sub_a = {rem_q, quo_q[M_W-1]};
			sub_b = {1'b0, u_q};
		end
	end

	assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
	assign fits   = !diff[M_W+1];
	assign rem_nx = fits ? diff[M_W-1:0] : sub_a[M_W-1:0];
	assign quo_nx = {quo_q[M_W-2:0], fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (start && x != '0 && y != '0) begin
						state_q <= R_GCD;
					end else if (start) begin
						done_q <= 1'b1;
					end
				end
				R_GCD: begin
					if (u_q == v_q) begin
						cnt_q   <= '0;
						state_q <= R_DIVX;
					end
				end
				R_DIVX: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(M_W - 1)) begin
						cnt_q   <= '0;
						state_q <= R_DIVY;
					end
				end
				R_DIVY: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(M_W - 1)) begin
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			R_IDLE: begin
				if (start) begin
					u_q  <= x;
					v_q  <= y;
					xs_q <= x;
					ys_q <= y;
					qx_q <= x;
					qy_q <= y;
				end
			end
			R_GCD: begin
				priority if (u_q == v_q) begin
					rem_q <= '0;
					quo_q <= xs_q;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q  <= u_q >> 1;
					v_q  <= v_q >> 1;
					xs_q <= xs_q >> 1;
					ys_q <= ys_q >> 1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_gt) begin
					u_q <= {1'b0, diff[M_W-1:1]};
				end else begin
					v_q <= {1'b0, diff[M_W-1:1]};
				end
			end
			R_DIVX: begin
				if (cnt_q == CNT_W'(M_W - 1)) begin
					qx_q  <= quo_nx;
					rem_q <= '0;
					quo_q <= ys_q;
				end else begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
				end
			end
			R_DIVY: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (cnt_q == CNT_W'(M_W - 1)) begin
					qy_q <= quo_nx;
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign qx   = qx_q;
	assign qy   = qy_q;

endmodule

FILE: rtl/core/rational_arithmetic_unit.sv
// Rational arithmetic unit top level: request handshake, sequencing and result register.
// One request takes four multiply steps on a single shared multiplier and one combine
// step, then for add, subtract, multiply and divide a binary gcd of up to about
// 4*OPERAND_BITS subtract-or-shift steps and two restoring divisions of 2*OPERAND_BITS
// steps each on one shared subtractor; gcd and divisions are skipped when an operand
// of the reduction is zero. Compare and unused operation codes skip the reduction.
// The input is not ready while a request is in flight; a finished result waits in the
// output register while the next request is accepted.
module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int OPERAND_BITS = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_axis_tvalid,
	output logic                                       s_axis_tready,
	// a_num, a_den, b_num, b_den from bit 0 up, zero padded
	input  logic [((4*OPERAND_BITS-2+7)/8)*8-1:0]      s_axis_tdata,
	// req_type
	input  logic [REQ_W-1:0]                           s_axis_tuser,
	output logic                                       m_axis_tvalid,
	input  logic                                       m_axis_tready,
	// res_num, res_den, cmp_sign from bit 0 up, zero padded
	output logic [OUT_TDATA_W-1:0]                     m_axis_tdata,
	// status
	output logic                                       m_axis_tuser
);

	localparam int OB    = OPERAND_BITS;
	localparam int N_W   = 2 * OB + 1;
	localparam int M_W   = 2 * OB;
	localparam int W_EXT = (M_W + 1 > RES_NUM_W) ? M_W + 1 : RES_NUM_W;
	localparam int PAD_W = OUT_TDATA_W - RES_NUM_W - RES_DEN_W - CMP_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROD,
		ST_RED,
		ST_HOLD
	} state_t;

	state_t                 state_q;
	op_t                    op_q;
	logic [OB-1:0]          a_num_q, b_num_q;
	logic [OB-2:0]          a_den_q, b_den_q;
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;
	logic                   m_user_q;

	logic                   xp_start, xp_done;
	logic [N_W-1:0]         n_w, d_w;
	logic                   rd_start, rd_done;
	logic [M_W-1:0]         mn, md, qx, qy;
	logic [N_W-1:0]         n_abs, d_abs;

	logic                   is_arith;
	logic                   neg, d_zero;
	logic [W_EXT-1:0]       qx_ext, qy_ext, rn_ext;
	logic [RES_NUM_W-1:0]   res_num;
	logic [RES_DEN_W-1:0]   res_den;
	logic [CMP_W-1:0]       cmp_sign;
	logic                   status;
	logic                   res_ready, out_free, in_xfer;

	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = state_q == ST_IDLE;
	assign xp_start = in_xfer;

	rau_xprod #(
		.OPERAND_BITS(OB)
	) u_xprod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (xp_start),
		.op    (op_q),
		.a_num (a_num_q),
		.a_den (a_den_q),
		.b_num (b_num_q),
		.b_den (b_den_q),
		.done  (xp_done),
		.n     (n_w),
		.d     (d_w)
	);

	assign n_abs = n_w[N_W-1] ? (~n_w + 1'b1) : n_w;
	assign d_abs = d_w[N_W-1] ? (~d_w + 1'b1) : d_w;
	assign mn    = n_abs[M_W-1:0];
	assign md    = d_abs[M_W-1:0];

	always_comb begin
		unique case (op_q)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: is_arith = 1'b1;
			default:                        is_arith = 1'b0;
		endcase
	end

	assign rd_start = (state_q == ST_PROD) && xp_done && is_arith;

	rau_reduce #(
		.M_W(M_W)
	) u_reduce (
		.clk   (clk),
		.arst_n(arst_n),
		.start (rd_start),
		.x     (mn),
		.y     (md),
		.done  (rd_done),
		.qx    (qx),
		.qy    (qy)
	);

	assign d_zero = d_w == '0;
	assign neg    = n_w[N_W-1] != (d_w[N_W-1] || d_zero);
	assign qx_ext = {{(W_EXT-M_W){1'b0}}, qx};
	assign qy_ext = {{(W_EXT-M_W){1'b0}}, qy};
	assign rn_ext = neg ? (~qx_ext + 1'b1) : qx_ext;

	always_comb begin
		res_num  = '0;
		res_den  = '0;
		cmp_sign = CMP_EQ;
		status   = 1'b0;
		if (is_arith) begin
			res_num = rn_ext[RES_NUM_W-1:0];
			res_den = qy_ext[RES_DEN_W-1:0];
			status  = d_zero;
		end else if (op_q == OP_CMP && mn != '0) begin
			cmp_sign = neg ? CMP_LT : CMP_GT;
		end
	end

	assign res_ready = ((state_q == ST_PROD) && xp_done && !is_arith) ||
		((state_q == ST_RED) && rd_done) || (state_q == ST_HOLD);
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_user_q  <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (res_ready && out_free) begin
				m_valid_q <= 1'b1;
				m_data_q  <= {{PAD_W{1'b0}}, cmp_sign, res_den, res_num};
				m_user_q  <= status;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					if (xp_done) begin
						priority if (is_arith) begin
							state_q <= ST_RED;
						end else if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_RED: begin
					if (rd_done) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= op_t'(s_axis_tuser);
			a_num_q <= s_axis_tdata[OB-1:0];
			a_den_q <= s_axis_tdata[2*OB-2:OB];
			b_num_q <= s_axis_tdata[3*OB-2:2*OB-1];
			b_den_q <= s_axis_tdata[4*OB-3:3*OB-1];
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	a_xp_done_in_prod: assert property (@(posedge clk) disable iff (!arst_n)
		xp_done |-> state_q == ST_PROD)
		else $error("cross products finished outside the product phase");

	a_rd_done_in_red: assert property (@(posedge clk) disable iff (!arst_n)
		rd_done |-> state_q == ST_RED || state_q == ST_PROD)
		else $error("reduction finished outside the reduction phase");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_PROD)
		else $error("accepted request did not start the product phase");

	a_status_den: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_user_q |-> m_data_q[RES_NUM_W +: RES_DEN_W] == '0)
		else $error("divide-by-zero status with nonzero denominator");

	a_cmp_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> m_data_q[RES_NUM_W+RES_DEN_W +: CMP_W] != 2'b10)
		else $error("compare sign out of range");

	a_cmp_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_data_q[RES_NUM_W+RES_DEN_W +: CMP_W] != CMP_EQ
			|-> m_data_q[RES_NUM_W-1:0] == '0 && !m_user_q)
		else $error("compare result carries arithmetic fields");

endmodule

FILE: dv/testbench.sv
// Self-checking stream testbench for the rational arithmetic unit.
`timescale 1ns / 1ps

module testbench;
	import rau_pkg::*;

	localparam int OPERAND_BITS = 16;
	localparam int NUM_W        = OPERAND_BITS;
	localparam int DEN_W        = OPERAND_BITS - 1;
	localparam int IN_TDATA_W   = ((4*OPERAND_BITS-2+7)/8)*8;
	localparam int RANDOM_ITEMS = 1800;
	localparam int STEADY_FROM  = 900;
	localparam int STEADY_TO    = 1200;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 200;
	localparam longint CYCLE_LIMIT = 1000000;

	localparam logic [REQ_W-1:0] OP_SPARE_LO  = 3'd5;
	localparam logic [REQ_W-1:0] OP_SPARE_MID = 3'd6;
	localparam logic [REQ_W-1:0] OP_SPARE_HI  = 3'd7;

	typedef struct {
		logic [REQ_W-1:0]        op;
		logic signed [NUM_W-1:0] a_num;
		logic [DEN_W-1:0]        a_den;
		logic signed [NUM_W-1:0] b_num;
		logic [DEN_W-1:0]        b_den;
	} request_t;

	typedef struct {
		logic signed [RES_NUM_W-1:0] num;
		logic [RES_DEN_W-1:0]        den;
		logic [CMP_W-1:0]            cmp;
		logic                        status;
	} outcome_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [REQ_W-1:0]       s_axis_tuser  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	request_t pending[$];
	outcome_t expected_results[$];
	request_t in_flight;
	int       accepted_count = 0;
	int       result_count   = 0;
	int       error_count    = 0;
	int       op_count[8];
	int       hold_left      = 0;
	logic     hold_done      = 1'b0;
	longint   cycle_count    = 0;
	logic     steady;

	rational_arithmetic_unit #(.OPERAND_BITS(OPERAND_BITS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	assign steady = accepted_count >= STEADY_FROM && accepted_count < STEADY_TO;

	function automatic longint unsigned common_factor(longint unsigned x, longint unsigned y);
		longint unsigned t;
		if (x == 0 || y == 0) begin
			return 1;
		end
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic outcome_t rational_result(request_t r);
		longint          an, ad, bn, bd, n, d, rn;
		longint unsigned mn, md, g;
		outcome_t        o;
		o = '{num: '0, den: '0, cmp: CMP_EQ, status: 1'b0};
		an = r.a_num;
		ad = r.a_den;
		bn = r.b_num;
		bd = r.b_den;
		case (r.op)
			OP_ADD: begin n = an*bd + ad*bn; d = ad*bd; end
			OP_SUB: begin n = an*bd - ad*bn; d = ad*bd; end
			OP_MUL: begin n = an*bn;         d = ad*bd; end
			OP_DIV: begin n = an*bd;         d = ad*bn; end
			OP_CMP: begin n = an*bd - ad*bn; d = ad*bd; end
			default: return o;
		endcase
		mn = n < 0 ? -n : n;
		md = d < 0 ? -d : d;
		g  = common_factor(mn, md);
		rn = ((n < 0) != (d <= 0)) ? -longint'(mn / g) : longint'(mn / g);
		if (r.op == OP_CMP) begin
			o.cmp = rn < 0 ? CMP_LT : (rn > 0 ? CMP_GT : CMP_EQ);
			return o;
		end
		o.num    = rn[RES_NUM_W-1:0];
		o.den    = RES_DEN_W'(md / g);
		o.status = d == 0;
		return o;
	endfunction

	function automatic logic signed [NUM_W-1:0] random_num();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30) return NUM_W'($urandom);
		if (pick < 60) return NUM_W'($urandom_range(80) - 40);
		if (pick < 70) begin
			case ($urandom_range(4))
				0: return NUM_W'(-32768);
				1: return NUM_W'(32767);
				2: return NUM_W'(0);
				3: return NUM_W'(-1);
				default: return NUM_W'(1);
			endcase
		end
		return NUM_W'(($urandom_range(1) ? -1 : 1) * $urandom_range(1, 180) *
			$urandom_range(180));
	endfunction

	function automatic logic [DEN_W-1:0] random_den();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35) return DEN_W'($urandom_range(1, 32767));
		if (pick < 65) return DEN_W'($urandom_range(1, 60));
		if (pick < 72) return $urandom_range(1) ? DEN_W'(32767) : DEN_W'(1);
		if (pick < 75) return DEN_W'(0);
		return DEN_W'($urandom_range(1, 180) * $urandom_range(1, 180));
	endfunction

	task automatic queue_request(logic [REQ_W-1:0] op, int an, int ad, int bn, int bd);
		request_t r;
		r.op    = op;
		r.a_num = NUM_W'(an);
		r.a_den = DEN_W'(ad);
		r.b_num = NUM_W'(bn);
		r.b_den = DEN_W'(bd);
		pending.push_back(r);
	endtask

	task automatic report_mismatch(string field, longint got, longint want);
		$display("%0t: %s is %0d, expected %0d", $time, field, got, want);
		error_count++;
	endtask

	// Driver: advance to the next pending item once the current one transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				expected_results.push_back(rational_result(in_flight));
				op_count[in_flight.op]++;
				accepted_count <= accepted_count + 1;
			end
			if (pending.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
				in_flight = pending.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {{(IN_TDATA_W-4*OPERAND_BITS+2){1'b0}}, in_flight.b_den,
					in_flight.b_num, in_flight.a_den, in_flight.a_num};
				s_axis_tuser  <= in_flight.op;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Hold off the receiver once for a long stretch so the input backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && accepted_count >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= hold_left == 0 && (steady || $urandom_range(99) >= 14);
		end
	end

	// Monitor: check each result transfer against the oldest prediction.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			result_count++;
			if (expected_results.size() == 0) begin
				report_mismatch("outstanding requests at result transfer", 0, 1);
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[31:0] !== want.num)
					report_mismatch("res_num", $signed(m_axis_tdata[31:0]), want.num);
				if (m_axis_tdata[62:32] !== want.den)
					report_mismatch("res_den", m_axis_tdata[62:32], want.den);
				if (m_axis_tdata[64:63] !== want.cmp)
					report_mismatch("cmp_sign", $signed(m_axis_tdata[64:63]),
						$signed(want.cmp));
				if (m_axis_tuser !== want.status)
					report_mismatch("status", m_axis_tuser, want.status);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_results.size());
			$display("rational_arithmetic_unit: mismatch");
			$finish;
		end
	end

	initial begin
		request_t r;
		foreach (op_count[i]) op_count[i] = 0;

		queue_request(OP_ADD, 1, 2, 1, 2);
		queue_request(OP_ADD, -32768, 1, -32768, 1);
		queue_request(OP_ADD, 32767, 32767, 32767, 1);
		queue_request(OP_SUB, 3, 4, 3, 4);
		queue_request(OP_SUB, -32768, 32767, 32767, 1);
		queue_request(OP_MUL, -32768, 1, -32768, 1);
		queue_request(OP_MUL, 32767, 32767, 32767, 32767);
		queue_request(OP_MUL, 0, 5, 7, 3);
		queue_request(OP_DIV, 1, 3, 0, 7);
		queue_request(OP_DIV, -32768, 32767, 32767, 32767);
		queue_request(OP_DIV, 6, 4, -3, 2);
		queue_request(OP_CMP, 1, 2, 2, 4);
		queue_request(OP_CMP, -1, 1, 1, 1);
		queue_request(OP_CMP, 32767, 1, -32768, 1);
		queue_request(OP_ADD, 1, 0, 1, 0);
		queue_request(OP_SUB, 5, 0, 3, 7);
		queue_request(OP_DIV, 5, 0, 3, 2);
		queue_request(OP_CMP, 5, 0, -3, 7);
		queue_request(OP_MUL, -7, 0, 0, 9);
		queue_request(OP_SPARE_LO, 12, 5, -9, 4);
		queue_request(OP_SPARE_MID, -32768, 32767, 32767, 0);
		queue_request(OP_SPARE_HI, 1, 1, 1, 1);

		repeat (RANDOM_ITEMS) begin
			if ($urandom_range(99) < 96)
				r.op = REQ_W'($urandom_range(OP_ADD, OP_CMP));
			else
				r.op = REQ_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			r.a_num = random_num();
			r.a_den = random_den();
			r.b_num = random_num();
			r.b_den = random_den();
			pending.push_back(r);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (pending.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests checked against %0d results in %0d cycles", accepted_count,
			result_count, cycle_count);
		$display("add %0d, sub %0d, mul %0d, div %0d, cmp %0d, unused codes %0d",
			op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_DIV],
			op_count[OP_CMP], op_count[OP_SPARE_LO] + op_count[OP_SPARE_MID] +
			op_count[OP_SPARE_HI]);
		if (error_count == 0) begin
			$display("rational_arithmetic_unit: match");
		end else begin
			$display("rational_arithmetic_unit: mismatch");
		end
		$finish;
	end

endmodule
